[rtl/core/mcp_pkg.sv]
// ---------------------------------------------------------------------------
// mcp_pkg
// Shared widths, limits and types of the midpoint circle point generator.
// ---------------------------------------------------------------------------
package mcp_pkg;

    // field widths
    localparam int CX_W  = 12;
    localparam int R_W   = 6;
    localparam int PT_W  = 14;

    // generator arithmetic widths
    localparam int ERR_W  = 11;
    localparam int STEP_W = 8;
    localparam int CNT_W  = 7;

    // default radius bound and per-circle group limit
    localparam int MAX_RADIUS_DEF = 40;
    localparam int RESULT_LIMIT   = 64;

    // circles held between front and back
    localparam int QUEUE_DEPTH = 2;

    // stream word widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 8 * PT_W;

    // one circle as it travels through the queue
    typedef struct packed {
        logic [CX_W-1:0] cx;
        logic [CX_W-1:0] cy;
        logic [R_W-1:0]  r;
    } circle_t;

    // queue fill status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } q_flags_t;

endpackage

[rtl/core/mcp_front.sv]
// ---------------------------------------------------------------------------
// mcp_front
// Input side: takes circle words, bounds the radius and pushes the queue.
// ---------------------------------------------------------------------------
module mcp_front
    import mcp_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // fields from bit 0: center_x[11:0], center_y[23:12], circle_radius[29:24]
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    input  q_flags_t            q_flags,
    output logic                wr_en,
    output circle_t             wr_data
);

    logic [R_W-1:0] r_in;

    // accept whenever the queue has a free slot
    assign s_axis_tready = !q_flags.full;
    assign wr_en         = s_axis_tvalid && !q_flags.full;

    // unpack and saturate the radius to the bound
    assign r_in       = s_axis_tdata[2*CX_W +: R_W];
    assign wr_data.cx = s_axis_tdata[0 +: CX_W];
    assign wr_data.cy = s_axis_tdata[CX_W +: CX_W];
    assign wr_data.r  = (r_in > R_W'(MAX_RADIUS)) ? R_W'(MAX_RADIUS) : r_in;

endmodule

[rtl/core/mcp_queue.sv]
// ---------------------------------------------------------------------------
// mcp_queue
// Short circle queue that decouples the input side from the generator.
// ---------------------------------------------------------------------------
module mcp_queue
    import mcp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_en,
    input  circle_t  wr_data,
    input  logic     rd_en,
    output circle_t  rd_data,
    output q_flags_t q_flags
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);

    circle_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign q_flags.empty = (cnt_reg == '0);
    assign q_flags.full  = (cnt_reg == CNT_QW'(DEPTH));
    assign do_wr         = wr_en && !q_flags.full;
    assign do_rd         = rd_en && !q_flags.empty;
    assign rd_data       = mem[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/core/mcp_gen.sv]
// ---------------------------------------------------------------------------
// mcp_gen
// Back end: midpoint stepper that emits one point group per cycle, while the
// output is not stalled, into a registered output word.
// ---------------------------------------------------------------------------
module mcp_gen
    import mcp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  q_flags_t            q_flags,
    input  circle_t             rd_data,
    output logic                rd_en,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // fields from bit 0: pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic                m_axis_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_STEP_A = 3'b010,
        ST_STEP_B = 3'b100
    } gen_state_t;

    gen_state_t                state_reg, state_next;
    logic [CX_W-1:0]           cx_reg, cx_next;
    logic [CX_W-1:0]           cy_reg, cy_next;
    logic [R_W-1:0]            a_reg, a_next;
    logic [R_W-1:0]            b_reg, b_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [STEP_W-1:0]  dx_reg, dx_next;
    logic signed [STEP_W-1:0]  dy_reg, dy_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic                      m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]       m_data_reg, m_data_next;
    logic                      m_last_reg, m_last_next;

    logic                      out_free;
    logic                      emit;
    logic                      err_ge;
    logic [R_W-1:0]            a_step, b_step;
    logic signed [STEP_W-1:0]  dx_step, dy_step;
    logic signed [ERR_W-1:0]   err_half, err_step;
    logic                      more_steps;

    // one coordinate: center plus or minus an offset, 14-bit wrap
    function automatic logic [PT_W-1:0] coord(input logic [CX_W-1:0] c,
                                              input logic [R_W-1:0] o,
                                              input logic neg);
        logic [PT_W-1:0] ce, oe;
        ce = PT_W'(c);
        oe = PT_W'(o);
        return neg ? (ce - oe) : (ce + oe);
    endfunction

    // four mirrored points (c+u, c+v), (c-u, c+v), (c+u, c-v), (c-u, c-v)
    function automatic logic [M_DATA_W-1:0] mirror4(input logic [CX_W-1:0] cx,
                                                    input logic [CX_W-1:0] cy,
                                                    input logic [R_W-1:0] u,
                                                    input logic [R_W-1:0] v);
        return {coord(cy, v, 1'b1), coord(cx, u, 1'b1),
                coord(cy, v, 1'b1), coord(cx, u, 1'b0),
                coord(cy, v, 1'b0), coord(cx, u, 1'b1),
                coord(cy, v, 1'b0), coord(cx, u, 1'b0)};
    endfunction

    // axis points: top, bottom, left, right
    function automatic logic [M_DATA_W-1:0] axis4(input logic [CX_W-1:0] cx,
                                                  input logic [CX_W-1:0] cy,
                                                  input logic [R_W-1:0] r);
        return {coord(cy, '0, 1'b0), coord(cx, r, 1'b0),
                coord(cy, '0, 1'b0), coord(cx, r, 1'b1),
                coord(cy, r, 1'b1),  coord(cx, '0, 1'b0),
                coord(cy, r, 1'b0),  coord(cx, '0, 1'b0)};
    endfunction

    assign out_free = !m_valid_reg || m_axis_tready;
    assign rd_en    = (state_reg == ST_IDLE) && !q_flags.empty && out_free;

    // one midpoint decision step
    assign err_ge   = !err_reg[ERR_W-1];
    assign b_step   = err_ge ? b_reg - 1'b1 : b_reg;
    assign dy_step  = err_ge ? dy_reg + STEP_W'(2) : dy_reg;
    assign err_half = err_ge ? err_reg + ERR_W'(dy_step) : err_reg;
    assign a_step   = a_reg + 1'b1;
    assign dx_step  = dx_reg + STEP_W'(2);
    assign err_step = err_half + ERR_W'(dx_step);

    // after a second group: another step if offsets allow and groups remain
    assign more_steps = (a_reg < b_reg)
                        && ((({1'b0, n_reg}) + (CNT_W+1)'(4)) <= (CNT_W+1)'(RESULT_LIMIT));

    // sequencer
    always_comb begin
        state_next  = state_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        err_next    = err_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        n_next      = n_reg;
        m_data_next = m_data_reg;
        m_last_next = m_last_reg;
        emit        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (rd_en) begin
                    emit        = 1'b1;
                    cx_next     = rd_data.cx;
                    cy_next     = rd_data.cy;
                    a_next      = '0;
                    b_next      = rd_data.r;
                    err_next    = ERR_W'(1) - ERR_W'(rd_data.r);
                    dx_next     = STEP_W'(1);
                    dy_next     = STEP_W'(0) - STEP_W'({rd_data.r, 1'b0});
                    n_next      = CNT_W'(1);
                    m_data_next = axis4(rd_data.cx, rd_data.cy, rd_data.r);
                    m_last_next = (rd_data.r == '0);
                    state_next  = (rd_data.r == '0) ? ST_IDLE : ST_STEP_A;
                end
            end
            ST_STEP_A: begin
                if (out_free) begin
                    emit        = 1'b1;
                    a_next      = a_step;
                    b_next      = b_step;
                    err_next    = err_step;
                    dx_next     = dx_step;
                    dy_next     = dy_step;
                    m_data_next = mirror4(cx_reg, cy_reg, a_step, b_step);
                    m_last_next = 1'b0;
                    state_next  = ST_STEP_B;
                end
            end
            ST_STEP_B: begin
                if (out_free) begin
                    emit        = 1'b1;
                    n_next      = n_reg + CNT_W'(2);
                    m_data_next = mirror4(cx_reg, cy_reg, b_reg, a_reg);
                    m_last_next = !more_steps;
                    state_next  = more_steps ? ST_STEP_A : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word register
    always_comb begin
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            n_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            n_reg       <= n_next;
        end
    end

    // working registers and payload
    always_ff @(posedge aclk) begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        err_reg    <= err_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // checks
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready) |=> m_valid_reg)
        else $error("output word dropped while stalled");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (state_reg == ST_IDLE))
        else $error("last word shown while stepper still busy");

    a_step_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP_A) |-> (a_reg < b_reg))
        else $error("step entered with x offset not below y offset");

    a_group_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (n_reg <= CNT_W'(RESULT_LIMIT - 2)))
        else $error("group count past limit");

endmodule

[rtl/core/midpoint_circle_points.sv]
// ---------------------------------------------------------------------------
// midpoint_circle_points
// Midpoint circle outline generator, four points per output word.
// ---------------------------------------------------------------------------
// Each input word is one circle (center and radius, radius bounded to
// MAX_RADIUS). The output is a run of words of four points each: first the
// four axis points, then two words per midpoint step, tlast on the final
// word. The generator emits one word per cycle while the output is not
// stalled. A two-entry queue in front of the generator takes new circles
// while the current one is still running, and the registered output lets
// the generator keep going until the output side stalls. No clearing pass
// after reset.
module midpoint_circle_points
    import mcp_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // fields from bit 0: center_x[11:0], center_y[23:12], circle_radius[29:24]
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // fields from bit 0: pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic                m_axis_tlast
);

    q_flags_t q_flags;
    logic     wr_en;
    circle_t  wr_data;
    logic     rd_en;
    circle_t  rd_data;

    // input side
    mcp_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_flags       (q_flags),
        .wr_en         (wr_en),
        .wr_data       (wr_data)
    );

    // circle queue
    mcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_data (rd_data),
        .q_flags (q_flags)
    );

    // point generator
    mcp_gen u_gen (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_flags       (q_flags),
        .rd_data       (rd_data),
        .rd_en         (rd_en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
